// File: src/sorted_priority_queue_assert.svh
// Assertion macros for the sorted priority queue.
// The macros sample on i_clk and are disabled while i_rst_n is low.
`ifndef SORTED_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_ASSERT_SVH
`ifndef SYNTHESIS
`define SPR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sorted_priority_queue: assertion failed");
`define SPR_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sorted_priority_queue: assertion failed");
`else
`define SPR_ASSERT_IMP(lbl, ante, cons)
`define SPR_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// File: src/spr_pkg.sv
`timescale 1ns / 1ps
package spr_pkg;

    localparam int CAPACITY      = 32;
    localparam int ELEMENT_BITS  = 16;
    localparam int PRIORITY_BITS = 16;
    localparam int ADDR_BITS     = $clog2(CAPACITY);
    localparam int IDX_BITS      = $clog2(CAPACITY + 1);
    localparam int ENTRY_BITS    = ELEMENT_BITS + PRIORITY_BITS;
    localparam int OCC_BITS      = 6;

    typedef enum logic [2:0] {
        MODE_INSERT,
        MODE_REMOVE_HEAD,
        MODE_REMOVE_ELEMENT,
        MODE_CHANGE,
        MODE_CONTAINS,
        MODE_FIRST,
        MODE_NEXT,
        MODE_CLEAR
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK,
        ST_MISS,
        ST_FULL
    } t_status;

    typedef enum logic [1:0] {
        KIND_INSERT,
        KIND_DELETE,
        KIND_FIND,
        KIND_READ
    } t_kind;

    typedef struct packed {
        t_mode                     mode;
        logic [ELEMENT_BITS-1:0]   element_id;
        logic [PRIORITY_BITS-1:0]  priority_req;
        logic [PRIORITY_BITS-1:0]  repl_priority;
    } t_in_word;

    typedef struct packed {
        t_status                   status;
        logic                      found;
        logic [ELEMENT_BITS-1:0]   out_element;
        logic [OCC_BITS-1:0]       occupancy;
    } t_out_word;

    typedef struct packed {
        logic  load;
        logic  start;
        t_kind kind;
        logic  use_new;
        logic  finish;
    } t_cmd;

    typedef struct packed {
        t_mode op;
        logic  empty;
        logic  full;
        logic  next_ok;
        logic  pass_done;
        logic  hit;
    } t_sts;

endpackage

// File: src/sorted_priority_queue.sv
`timescale 1ns / 1ps
// Channel  Direction  Handshake                 Word
// input    in         i_in_valid / o_in_stall   i_in_word  (spr_pkg::t_in_word)
// output   out        o_out_valid / i_out_stall o_out_word (spr_pkg::t_out_word)
//
// One operation at a time. Clear, and any operation that ends without a walk (empty or
// full queue, next with nothing left), read no entry; first and next read a single entry;
// insert, remove and contains walk the entry RAM once; change priority walks it twice
// when the entry is found and once when not.
// Reset (synchronous, active low) empties the queue and cancels iteration.
// A new word is taken once the block is idle and the last result is not stalled.
`include "sorted_priority_queue_assert.svh"
module sorted_priority_queue #(
    parameter int CAPACITY = spr_pkg::CAPACITY
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  spr_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output spr_pkg::t_out_word o_out_word
);

    localparam int OB = spr_pkg::OCC_BITS;

    spr_pkg::t_cmd w_cmd;
    spr_pkg::t_sts w_sts;
    logic          w_out_full;

    spr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    spr_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_in_word  (i_in_word),
        .o_sts      (w_sts),
        .o_out_word (o_out_word)
    );

    assign w_out_full = o_out_valid && (o_out_word.status == spr_pkg::ST_FULL);

    `SPR_ASSERT_IMP(a_occ_bound, o_out_valid, o_out_word.occupancy <= OB'(CAPACITY))
    `SPR_ASSERT_IMP(a_full_at_cap, w_out_full, o_out_word.occupancy == OB'(CAPACITY))
    `SPR_ASSERT_NXT(a_busy_after_accept, i_in_valid && !o_in_stall, o_in_stall)

endmodule

// File: src/spr_ram.sv
`timescale 1ns / 1ps
module spr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/spr_ctrl.sv
`timescale 1ns / 1ps
module spr_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    input  spr_pkg::t_sts i_sts,
    output spr_pkg::t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_PASS,
        S_POST,
        S_FIN
    } t_state;

    t_state        r_state;
    logic          r_phase;
    logic          r_out_vld;
    t_state        n_state;
    logic          w_accept;
    spr_pkg::t_cmd w_cmd;

    assign o_in_stall  = (r_state != S_IDLE) || (r_out_vld && i_out_stall);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_vld;
    assign o_cmd       = w_cmd;

    always_comb begin
        w_cmd         = '0;
        w_cmd.kind    = spr_pkg::KIND_INSERT;
        w_cmd.load    = w_accept;
        n_state       = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                case (i_sts.op)
                    spr_pkg::MODE_INSERT: begin
                        w_cmd.start = !i_sts.full;
                        w_cmd.kind  = spr_pkg::KIND_INSERT;
                    end
                    spr_pkg::MODE_REMOVE_HEAD,
                    spr_pkg::MODE_REMOVE_ELEMENT,
                    spr_pkg::MODE_CHANGE: begin
                        w_cmd.start = !i_sts.empty;
                        w_cmd.kind  = spr_pkg::KIND_DELETE;
                    end
                    spr_pkg::MODE_CONTAINS: begin
                        w_cmd.start = !i_sts.empty;
                        w_cmd.kind  = spr_pkg::KIND_FIND;
                    end
                    spr_pkg::MODE_FIRST: begin
                        w_cmd.start = !i_sts.empty;
                        w_cmd.kind  = spr_pkg::KIND_READ;
                    end
                    spr_pkg::MODE_NEXT: begin
                        w_cmd.start = i_sts.next_ok;
                        w_cmd.kind  = spr_pkg::KIND_READ;
                    end
                    default: begin
                        w_cmd.start = 1'b0;
                    end
                endcase
                n_state = w_cmd.start ? S_PASS : S_FIN;
            end
            S_PASS: begin
                if (i_sts.pass_done) begin
                    n_state = S_POST;
                end
            end
            S_POST: begin
                w_cmd.start   = (i_sts.op == spr_pkg::MODE_CHANGE) && !r_phase && i_sts.hit;
                w_cmd.kind    = spr_pkg::KIND_INSERT;
                w_cmd.use_new = 1'b1;
                n_state       = w_cmd.start ? S_PASS : S_FIN;
            end
            S_FIN: begin
                w_cmd.finish = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_phase   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_phase <= 1'b0;
            end else if (r_state == S_POST && w_cmd.start) begin
                r_phase <= 1'b1;
            end
            if (w_cmd.finish) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

endmodule

// File: src/spr_dp.sv
`timescale 1ns / 1ps
module spr_dp #(
    parameter int CAPACITY = spr_pkg::CAPACITY
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  spr_pkg::t_cmd      i_cmd,
    input  spr_pkg::t_in_word  i_in_word,
    output spr_pkg::t_sts      o_sts,
    output spr_pkg::t_out_word o_out_word
);

    localparam int AW = $clog2(CAPACITY);
    localparam int IW = $clog2(CAPACITY + 1);
    localparam int EB = spr_pkg::ELEMENT_BITS;
    localparam int PB = spr_pkg::PRIORITY_BITS;
    localparam int NB = spr_pkg::ENTRY_BITS;
    localparam int OB = spr_pkg::OCC_BITS;

    spr_pkg::t_mode     r_op;
    logic [EB-1:0]      r_elem;
    logic [PB-1:0]      r_prio;
    logic [PB-1:0]      r_nprio;
    logic [PB-1:0]      r_key;
    spr_pkg::t_kind     r_kind;
    logic [IW-1:0]      r_count;
    logic [AW-1:0]      r_cur;
    logic               r_cur_vld;
    logic [IW-1:0]      r_k;
    logic [IW-1:0]      r_last;
    logic               r_issue;
    logic               r_dv;
    logic [IW-1:0]      r_dk;
    logic [NB-1:0]      r_carry;
    logic               r_hit;
    logic               r_full0;
    logic [EB-1:0]      r_oel;
    spr_pkg::t_out_word r_out;

    logic [NB-1:0]      w_rdata;
    logic [EB-1:0]      w_v_elem;
    logic [PB-1:0]      w_v_prio;
    logic               w_inrange;
    logic               w_ins_cond;
    logic               w_del_match;
    logic               w_find_match;
    logic               w_pass_done;
    logic               w_we;
    logic [IW-1:0]      w_waddr;
    logic [NB-1:0]      w_wdata;
    logic [IW-1:0]      w_dk_prev;
    logic [IW-1:0]      w_cur_next;
    logic               w_is_iter;
    spr_pkg::t_out_word w_res;

    spr_ram #(
        .WIDTH (NB),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr[AW-1:0]),
        .i_wdata (w_wdata),
        .i_re    (r_issue),
        .i_raddr (r_k[AW-1:0]),
        .o_rdata (w_rdata)
    );

    assign w_v_elem     = w_rdata[NB-1:PB];
    assign w_v_prio     = w_rdata[PB-1:0];
    assign w_inrange    = r_dk < r_count;
    assign w_dk_prev    = r_dk - 1'b1;
    assign w_cur_next   = IW'(r_cur) + 1'b1;
    assign w_pass_done  = r_dv && (r_dk == r_last);
    assign w_find_match = w_v_elem == r_elem;
    assign w_is_iter    = (r_op == spr_pkg::MODE_FIRST) || (r_op == spr_pkg::MODE_NEXT);

    assign w_ins_cond = !r_hit && (!w_inrange ||
                        ((r_dk == '0) ? (r_key > w_v_prio) : !(w_v_prio > r_key)));

    assign w_del_match = (r_op == spr_pkg::MODE_REMOVE_HEAD) ? (r_dk == '0) :
                         (w_find_match &&
                          ((r_op != spr_pkg::MODE_CHANGE) || (w_v_prio == r_prio)));

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_dk;
        w_wdata = w_rdata;
        if (r_dv) begin
            case (r_kind)
                spr_pkg::KIND_INSERT: begin
                    if (r_hit) begin
                        w_we    = 1'b1;
                        w_wdata = r_carry;
                    end else if (w_ins_cond) begin
                        w_we    = 1'b1;
                        w_wdata = {r_elem, r_key};
                    end
                end
                spr_pkg::KIND_DELETE: begin
                    w_we    = r_hit;
                    w_waddr = w_dk_prev;
                end
                default: begin
                    w_we = 1'b0;
                end
            endcase
        end
    end

    always_comb begin
        w_res.occupancy   = (r_op == spr_pkg::MODE_CLEAR) ? '0 : OB'(r_count);
        w_res.found       = ((r_op == spr_pkg::MODE_CONTAINS) || w_is_iter) && r_hit;
        w_res.out_element = (w_is_iter && r_hit) ? r_oel : '0;
        case (r_op)
            spr_pkg::MODE_INSERT:   w_res.status = r_full0 ? spr_pkg::ST_FULL : spr_pkg::ST_OK;
            spr_pkg::MODE_CONTAINS: w_res.status = spr_pkg::ST_OK;
            spr_pkg::MODE_CLEAR:    w_res.status = spr_pkg::ST_OK;
            default:                w_res.status = r_hit ? spr_pkg::ST_OK : spr_pkg::ST_MISS;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_cur     <= '0;
            r_cur_vld <= 1'b0;
            r_k       <= '0;
            r_issue   <= 1'b0;
            r_dv      <= 1'b0;
            r_hit     <= 1'b0;
            r_full0   <= 1'b0;
        end else begin
            r_dv <= r_issue;
            if (r_issue) begin
                r_k <= r_k + 1'b1;
                if (r_k == r_last) begin
                    r_issue <= 1'b0;
                end
            end
            if (i_cmd.load) begin
                r_hit   <= 1'b0;
                r_full0 <= r_count == IW'(CAPACITY);
                if ((i_in_word.mode == spr_pkg::MODE_INSERT) ||
                    (i_in_word.mode == spr_pkg::MODE_REMOVE_HEAD) ||
                    (i_in_word.mode == spr_pkg::MODE_REMOVE_ELEMENT) ||
                    (i_in_word.mode == spr_pkg::MODE_CHANGE) ||
                    (i_in_word.mode == spr_pkg::MODE_CLEAR)) begin
                    r_cur_vld <= 1'b0;
                end
            end
            if (i_cmd.start) begin
                r_hit   <= 1'b0;
                r_issue <= 1'b1;
                if (i_cmd.kind == spr_pkg::KIND_READ && r_op == spr_pkg::MODE_NEXT) begin
                    r_k <= w_cur_next;
                end else begin
                    r_k <= '0;
                end
            end
            if (r_dv) begin
                case (r_kind)
                    spr_pkg::KIND_INSERT: r_hit <= r_hit | w_ins_cond;
                    spr_pkg::KIND_DELETE: r_hit <= r_hit | w_del_match;
                    spr_pkg::KIND_FIND:   r_hit <= r_hit | w_find_match;
                    default:              r_hit <= 1'b1;
                endcase
            end
            if (w_pass_done) begin
                if (r_kind == spr_pkg::KIND_INSERT) begin
                    r_count <= r_count + 1'b1;
                end else if (r_kind == spr_pkg::KIND_DELETE && (r_hit || w_del_match)) begin
                    r_count <= r_count - 1'b1;
                end
            end
            if (i_cmd.finish) begin
                if (r_op == spr_pkg::MODE_CLEAR) begin
                    r_count <= '0;
                end
                if (r_op == spr_pkg::MODE_FIRST && r_hit) begin
                    r_cur     <= '0;
                    r_cur_vld <= 1'b1;
                end
                if (r_op == spr_pkg::MODE_NEXT && r_hit) begin
                    r_cur <= w_cur_next[AW-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_dk    <= r_k;
        r_carry <= w_rdata;
        if (i_cmd.load) begin
            r_op    <= i_in_word.mode;
            r_elem  <= i_in_word.element_id;
            r_prio  <= i_in_word.priority_req;
            r_nprio <= i_in_word.repl_priority;
        end
        if (i_cmd.start) begin
            r_kind <= i_cmd.kind;
            r_key  <= i_cmd.use_new ? r_nprio : r_prio;
            case (i_cmd.kind)
                spr_pkg::KIND_INSERT: r_last <= r_count;
                spr_pkg::KIND_READ:   r_last <= (r_op == spr_pkg::MODE_NEXT) ? w_cur_next : '0;
                default:              r_last <= r_count - 1'b1;
            endcase
        end
        if (r_dv && r_kind == spr_pkg::KIND_READ) begin
            r_oel <= w_v_elem;
        end
        if (i_cmd.finish) begin
            r_out <= w_res;
        end
    end

    assign o_sts.op        = r_op;
    assign o_sts.empty     = r_count == '0;
    assign o_sts.full      = r_count == IW'(CAPACITY);
    assign o_sts.next_ok   = r_cur_vld && (w_cur_next < r_count);
    assign o_sts.pass_done = w_pass_done;
    assign o_sts.hit       = r_hit;
    assign o_out_word      = r_out;

endmodule
